@@ sv/kvs_pkg.sv @@
// Shared types and codes for the keyed value store.
// Holds the request and response structs and the internal lookup/write structs.
// No dependencies.
`default_nettype none

package kvs_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W    = 32;
    localparam int SIZE_W   = 4;
    localparam int VALUE_W  = 64;
    localparam int MAX_BYTES = 8;

    // Request kinds.
    typedef enum logic {
        REQ_READ  = 1'b0,
        REQ_WRITE = 1'b1
    } req_type_t;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // One request transaction.
    typedef struct packed {
        req_type_t           req_type;
        logic [KEY_W-1:0]    key;
        logic [SIZE_W-1:0]   size;
        logic [VALUE_W-1:0]  value;
    } req_t;

    // One response transaction.
    typedef struct packed {
        status_t             status;
        logic [VALUE_W-1:0]  read_value;
        logic [SIZE_W-1:0]   read_len;
    } rsp_t;

    // Result of the associative lookup for the current request.
    typedef struct packed {
        logic                hit;
        logic                full;
        logic [SIZE_W-1:0]   len;
        logic [VALUE_W-1:0]  bytes;
    } lkp_t;

    // Table update command: overwrite the matching slot or claim a free one.
    typedef struct packed {
        logic                 update;
        logic                 alloc;
        logic [KEY_W-1:0]     key;
        logic [SIZE_W-1:0]    len;
        logic [MAX_BYTES-1:0] byte_en;
        logic [VALUE_W-1:0]   data;
    } wr_t;

endpackage

`default_nettype wire

@@ sv/kvs_table.sv @@
// Slot storage of the keyed value store with a parallel key compare.
// Depends on kvs_pkg for the lookup and write command structs.
// Finds the lowest matching slot and the lowest free slot; applies updates.
`default_nettype none

module kvs_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int DATA_BYTES    = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [kvs_pkg::KEY_W-1:0] key,
    input  wire kvs_pkg::wr_t            wr,
    output kvs_pkg::lkp_t                lkp
);

    localparam int BYTE_W = 8 * DATA_BYTES;
    localparam int LEN_W  = $clog2(DATA_BYTES + 1);

    logic [TABLE_ENTRIES-1:0] slot_valid_reg;
    logic [kvs_pkg::KEY_W-1:0] slot_key_reg   [TABLE_ENTRIES];
    logic [LEN_W-1:0]          slot_len_reg   [TABLE_ENTRIES];
    logic [BYTE_W-1:0]         slot_bytes_reg [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] match;
    logic [TABLE_ENTRIES-1:0] hit_oh;
    logic [TABLE_ENTRIES-1:0] free;
    logic [TABLE_ENTRIES-1:0] free_oh;
    logic [LEN_W-1:0]         rd_len;
    logic [BYTE_W-1:0]        rd_bytes;

    // Compare the key against every valid slot.
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match[i] = slot_valid_reg[i] && (slot_key_reg[i] == key);
        end
    end

    // Keep only the lowest matching slot and the lowest free slot.
    assign hit_oh  = match & (~match + TABLE_ENTRIES'(1));
    assign free    = ~slot_valid_reg;
    assign free_oh = free & (~free + TABLE_ENTRIES'(1));

    // Read the selected slot through an AND-OR selector.
    always_comb
    begin
        rd_len   = '0;
        rd_bytes = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (hit_oh[i])
            begin
                rd_len   = rd_len | slot_len_reg[i];
                rd_bytes = rd_bytes | slot_bytes_reg[i];
            end
        end
    end

    always_comb
    begin
        lkp.hit   = |match;
        lkp.full  = ~|free;
        lkp.len   = kvs_pkg::SIZE_W'(rd_len);
        lkp.bytes = kvs_pkg::VALUE_W'(rd_bytes);
    end

    // Valid bits: cleared at reset, set when a slot is claimed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (wr.alloc)
        begin
            slot_valid_reg <= slot_valid_reg | free_oh;
        end
    end

    // Slot payload: byte-wise overwrite on update, full fill on allocation.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (wr.update && hit_oh[i])
            begin
                for (int b = 0; b < DATA_BYTES; b++)
                begin
                    if (wr.byte_en[b])
                    begin
                        slot_bytes_reg[i][8*b +: 8] <= wr.data[8*b +: 8];
                    end
                end
            end
            if (wr.alloc && free_oh[i])
            begin
                slot_key_reg[i] <= wr.key;
                slot_len_reg[i] <= wr.len[LEN_W-1:0];
                for (int b = 0; b < DATA_BYTES; b++)
                begin
                    slot_bytes_reg[i][8*b +: 8] <= wr.byte_en[b] ? wr.data[8*b +: 8] : 8'h00;
                end
            end
        end
    end

    // An allocation only happens for a key that is not present.
    assert property (@(posedge clk) disable iff (!rst_n) wr.alloc |-> (match == '0))
        else $error("allocation issued for a key already in the table");

    // An update only happens for a key that is present.
    assert property (@(posedge clk) disable iff (!rst_n) wr.update |-> (match != '0))
        else $error("update issued for a key not in the table");

    // Each allocation fills exactly one more slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.alloc |=> ($countones(slot_valid_reg) == $past($countones(slot_valid_reg)) + 1))
        else $error("allocation did not claim exactly one slot");

endmodule

`default_nettype wire

@@ sv/kvs_exec.sv @@
// Request decode for the keyed value store: builds the response and table update.
// Depends on kvs_pkg for request, response, lookup and write command structs.
// Purely combinational; the table update is gated by fire.
`default_nettype none

module kvs_exec #(
    parameter int DATA_BYTES = 8
) (
    input  wire kvs_pkg::req_t  req,
    input  wire kvs_pkg::lkp_t  lkp,
    input  wire logic           fire,
    output kvs_pkg::rsp_t       rsp,
    output kvs_pkg::wr_t        wr
);

    logic [kvs_pkg::SIZE_W-1:0]    sz;
    logic [kvs_pkg::SIZE_W-1:0]    n;
    logic [kvs_pkg::MAX_BYTES-1:0] n_en;
    logic [kvs_pkg::MAX_BYTES-1:0] sz_en;
    logic [kvs_pkg::VALUE_W-1:0]   rd_masked;

    // Saturate the size and take the overlap with the stored length.
    always_comb
    begin
        sz = (req.size > kvs_pkg::SIZE_W'(DATA_BYTES)) ? kvs_pkg::SIZE_W'(DATA_BYTES)
                                                       : req.size;
        n  = (sz < lkp.len) ? sz : lkp.len;
        for (int i = 0; i < kvs_pkg::MAX_BYTES; i++)
        begin
            n_en[i]  = kvs_pkg::SIZE_W'(i) < n;
            sz_en[i] = kvs_pkg::SIZE_W'(i) < sz;
            rd_masked[8*i +: 8] = n_en[i] ? lkp.bytes[8*i +: 8] : 8'h00;
        end
    end

    // Response and table update for the request kind.
    always_comb
    begin
        rsp.status     = kvs_pkg::ST_OK;
        rsp.read_value = '0;
        rsp.read_len   = '0;
        wr.update      = 1'b0;
        wr.alloc       = 1'b0;
        wr.key         = req.key;
        wr.len         = sz;
        wr.byte_en     = n_en;
        wr.data        = req.value;
        case (req.req_type)
            kvs_pkg::REQ_READ:
            begin
                if (lkp.hit)
                begin
                    rsp.read_value = rd_masked;
                    rsp.read_len   = n;
                end
                else
                begin
                    rsp.status = kvs_pkg::ST_NOT_FOUND;
                end
            end
            kvs_pkg::REQ_WRITE:
            begin
                if (lkp.hit)
                begin
                    wr.update = fire;
                end
                else if (lkp.full)
                begin
                    rsp.status = kvs_pkg::ST_FULL;
                end
                else
                begin
                    wr.alloc   = fire;
                    wr.byte_en = sz_en;
                end
            end
            default:
            begin
                rsp.status = kvs_pkg::ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/keyed_value_store.sv @@
// Keyed value store: fully associative table of 32-bit keys with short values.
// A request is held in the request register, then moved into the response register.
// Throughput: one request per cycle unless the response side stalls; the key compare is
// combinational and the table change is seen by the request that follows directly.
// Reset empties the table by clearing the slot valid bits at once; no clearing pass.
// Depends on kvs_pkg, kvs_table and kvs_exec.
`default_nettype none

module keyed_value_store #(
    parameter int TABLE_ENTRIES = 16,
    parameter int DATA_BYTES    = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire kvs_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output kvs_pkg::rsp_t       rsp
);

    logic          req_vld_reg;
    kvs_pkg::req_t req_reg;
    logic          rsp_vld_reg;
    kvs_pkg::rsp_t rsp_reg;
    kvs_pkg::rsp_t rsp_next;
    kvs_pkg::lkp_t lkp;
    kvs_pkg::wr_t  wr;
    logic          advance;

    // Move the held request into the response register when it has room.
    assign advance   = req_vld_reg && (!rsp_vld_reg || rsp_ready);
    assign req_ready = !req_vld_reg || advance;
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    kvs_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .DATA_BYTES    (DATA_BYTES)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (req_reg.key),
        .wr    (wr),
        .lkp   (lkp)
    );

    kvs_exec #(
        .DATA_BYTES (DATA_BYTES)
    ) u_exec (
        .req  (req_reg),
        .lkp  (lkp),
        .fire (advance),
        .rsp  (rsp_next),
        .wr   (wr)
    );

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                req_vld_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // A held request is never dropped while the response side is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_vld_reg && rsp_vld_reg && !rsp_ready) |=> (req_vld_reg && $stable(req_reg)))
        else $error("held request lost during output stall");

    // The table changes only when a request moves to the response register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr.update || wr.alloc) |-> advance)
        else $error("table written without a completing transaction");

    // A completed request always leaves a response valid.
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> rsp_vld_reg)
        else $error("response not presented after completion");

endmodule

`default_nettype wire

@@ dv/keyed_value_store_tb.sv @@
// Self-checking testbench for keyed_value_store: directed and random read/write traffic.
// A built-in predictor of the key table checks every response. Depends on kvs_pkg and the DUT.
`default_nettype none

module keyed_value_store_tb;

    localparam int TABLE_ENTRIES = 16;
    localparam int DATA_BYTES    = 8;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int KEY_POOL      = 24;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int HOLD_START    = 300;
    localparam int HOLD_CYCLES   = 300;

    // Receiver stall patterns, one per stretch of cycles.
    typedef enum int {
        RX_STEADY,
        RX_CHOPPY,
        RX_SLUGGISH
    } rx_mode_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    kvs_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    kvs_pkg::rsp_t rsp;

    // Shadow copy of the key table.
    logic                       table_valid [TABLE_ENTRIES];
    logic [kvs_pkg::KEY_W-1:0]  table_key   [TABLE_ENTRIES];
    logic [kvs_pkg::SIZE_W-1:0] table_len   [TABLE_ENTRIES];
    logic [63:0]                table_bytes [TABLE_ENTRIES];

    kvs_pkg::req_t pending_reqs[$];
    kvs_pkg::rsp_t expected_rsps[$];
    logic [kvs_pkg::KEY_W-1:0] key_pool[KEY_POOL];

    int error_count    = 0;
    int rsp_count      = 0;
    int accepted_count = 0;
    int total_items    = 0;
    int cycle_count    = 0;
    logic req_fire     = 1'b0;

    // Sender burst state.
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver stall state.
    rx_mode_t rx_mode     = RX_STEADY;
    int  stretch_left     = 0;
    int  hold_left        = 0;
    bit  pressure_done    = 1'b0;

    keyed_value_store #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .DATA_BYTES   (DATA_BYTES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mask covering the low n bytes of a value word.
    function automatic logic [63:0] low_bytes_mask(int n);
        if (n >= 8)
        begin
            return '1;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Applies one request to the shadow table and returns the response it must produce.
    function automatic kvs_pkg::rsp_t predict_response(kvs_pkg::req_t r);
        kvs_pkg::rsp_t result;
        int          hit;
        int          free_slot;
        int          n;
        logic [63:0] m;
        result = '0;
        result.status = kvs_pkg::ST_OK;
        hit = -1;
        free_slot = -1;
        n = (int'(r.size) > DATA_BYTES) ? DATA_BYTES : int'(r.size);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (hit < 0 && table_valid[i] && table_key[i] == r.key)
                hit = i;
            if (free_slot < 0 && !table_valid[i])
                free_slot = i;
        end
        if (r.req_type == kvs_pkg::REQ_READ)
        begin
            if (hit < 0)
            begin
                result.status = kvs_pkg::ST_NOT_FOUND;
            end
            else
            begin
                if (int'(table_len[hit]) < n)
                    n = int'(table_len[hit]);
                result.read_value = table_bytes[hit] & low_bytes_mask(n);
                result.read_len   = kvs_pkg::SIZE_W'(n);
            end
        end
        else if (hit >= 0)
        begin
            // Overwrite within the stored length; the length itself stays.
            if (int'(table_len[hit]) < n)
                n = int'(table_len[hit]);
            m = low_bytes_mask(n);
            table_bytes[hit] = (table_bytes[hit] & ~m) | (r.value & m);
        end
        else if (free_slot < 0)
        begin
            result.status = kvs_pkg::ST_FULL;
        end
        else
        begin
            table_valid[free_slot] = 1'b1;
            table_key[free_slot]   = r.key;
            table_len[free_slot]   = kvs_pkg::SIZE_W'(n);
            table_bytes[free_slot] = r.value & low_bytes_mask(n);
        end
        return result;
    endfunction

    function automatic void queue_request(kvs_pkg::req_type_t t,
                                          logic [kvs_pkg::KEY_W-1:0] k,
                                          logic [kvs_pkg::SIZE_W-1:0] s, logic [63:0] v);
        kvs_pkg::req_t r;
        r.req_type = t;
        r.key      = k;
        r.size     = s;
        r.value    = v;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly legal sizes, now and then one above the byte count (up to 15) to exercise saturation.
    function automatic logic [kvs_pkg::SIZE_W-1:0] random_size();
        if ($urandom_range(0, 5) == 0)
            return kvs_pkg::SIZE_W'($urandom_range(DATA_BYTES + 1, 15));
        return kvs_pkg::SIZE_W'($urandom_range(0, DATA_BYTES));
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("response %0d: %s: got %h, expected %h", rsp_count, what, got, want);
    endtask

    // Sender: one transaction held until taken, offered in bursts separated by gaps.
    always @(negedge clk)
    begin
        logic offer;
        offer = req_valid && !req_fire;
        if (rst_n && !offer)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_reqs.size() > 0)
            begin
                req <= pending_reqs.pop_front();
                offer = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                             : $urandom_range(1, 20);
                end
            end
        end
        req_valid <= offer;
    end

    // Receiver: its own stall pattern, plus one long hold-off to back the block up.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else if (!pressure_done && rsp_count >= HOLD_START)
        begin
            pressure_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (stretch_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                stretch_left = $urandom_range(5, 60);
            end
            stretch_left--;
            case (rx_mode)
                RX_STEADY:   rsp_ready <= 1'b1;
                RX_CHOPPY:   rsp_ready <= ($urandom_range(0, 1) == 0);
                default:     rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: check responses against the oldest prediction, predict each accepted request.
    always @(posedge clk)
    begin
        kvs_pkg::rsp_t want;
        req_fire <= req_valid && req_ready;
        if (rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                report_mismatch("response with nothing pending", rsp.read_value, '0);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", 64'(rsp.status), 64'(want.status));
                if (rsp.read_value !== want.read_value)
                    report_mismatch("read_value", rsp.read_value, want.read_value);
                if (rsp.read_len !== want.read_len)
                    report_mismatch("read_len", 64'(rsp.read_len), 64'(want.read_len));
            end
            rsp_count++;
        end
        if (req_valid && req_ready)
        begin
            expected_rsps.push_back(predict_response(req));
            accepted_count++;
        end
    end

    // Watchdog on total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int pick;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            table_valid[i] = 1'b0;
            table_key[i]   = '0;
            table_len[i]   = '0;
            table_bytes[i] = '0;
        end

        // Directed: empty-table miss, zero-length entries, saturation, partial overwrite.
        queue_request(kvs_pkg::REQ_READ,  32'h0000_0000, 4'd8,  '0);
        queue_request(kvs_pkg::REQ_WRITE, 32'h0000_0000, 4'd0,  '1);
        queue_request(kvs_pkg::REQ_READ,  32'h0000_0000, 4'd8,  '0);
        queue_request(kvs_pkg::REQ_WRITE, 32'h0000_0000, 4'd8,  '1);
        queue_request(kvs_pkg::REQ_READ,  32'h0000_0000, 4'd0,  '1);
        queue_request(kvs_pkg::REQ_WRITE, 32'hFFFF_FFFF, 4'd8,  '1);
        queue_request(kvs_pkg::REQ_READ,  32'hFFFF_FFFF, 4'd15, '0);
        queue_request(kvs_pkg::REQ_READ,  32'hFFFF_FFFF, 4'd0,  '0);
        queue_request(kvs_pkg::REQ_READ,  32'hFFFF_FFFF, 4'd3,  '0);
        queue_request(kvs_pkg::REQ_WRITE, 32'hFFFF_FFFF, 4'd2,  '0);
        queue_request(kvs_pkg::REQ_READ,  32'hFFFF_FFFF, 4'd8,  '0);
        queue_request(kvs_pkg::REQ_WRITE, 32'h4B45_5931, 4'd12, random_word());
        queue_request(kvs_pkg::REQ_READ,  32'h4B45_5931, 4'd9,  '0);
        queue_request(kvs_pkg::REQ_WRITE, 32'h8000_0001, 4'd5,  '1);
        queue_request(kvs_pkg::REQ_READ,  32'h8000_0001, 4'd8,  '0);
        queue_request(kvs_pkg::REQ_WRITE, 32'h8000_0001, 4'd15, '0);
        queue_request(kvs_pkg::REQ_READ,  32'h8000_0001, 4'd7,  '1);
        queue_request(kvs_pkg::REQ_READ,  32'h4B45_5931, 4'd4,  '0);
        queue_request(kvs_pkg::REQ_WRITE, 32'hFFFF_FFFF, 4'd1,  64'h5555_5555_5555_55AA);
        queue_request(kvs_pkg::REQ_READ,  32'hFFFF_FFFF, 4'd8,  '0);

        // Key pool: more keys than slots, so the table fills and later new keys are refused.
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h4B45_5931;
        key_pool[3] = 32'h8000_0001;
        for (int i = 4; i < KEY_POOL; i++)
            key_pool[i] = $urandom();

        // Random: mostly traffic on pooled keys, some reads and writes of stray keys.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                queue_request(kvs_pkg::REQ_WRITE, key_pool[$urandom_range(0, KEY_POOL - 1)],
                              random_size(), random_word());
            else if (pick < 85)
                queue_request(kvs_pkg::REQ_READ, key_pool[$urandom_range(0, KEY_POOL - 1)],
                              random_size(), random_word());
            else if (pick < 95)
                queue_request(kvs_pkg::REQ_READ, $urandom(), random_size(), random_word());
            else
                queue_request(kvs_pkg::REQ_WRITE, $urandom(), random_size(), random_word());
        end
        total_items = pending_reqs.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every request is taken and answered, then let the pipe settle.
        while (accepted_count < total_items || expected_rsps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
sv/kvs_pkg.sv
sv/kvs_table.sv
sv/kvs_exec.sv
sv/keyed_value_store.sv
dv/keyed_value_store_tb.sv
